// File: rtl/bpdc_pkg.sv
// ----------------------------------------------------------------------------
// bpdc_pkg: shared types and constants of the button press classifier
// Event codes, field widths, register indexes and the cell interface types.
// ----------------------------------------------------------------------------
package bpdc_pkg;

	localparam int BUTTONS_DEF    = 8;
	localparam int TICK_WIDTH_DEF = 20;

	localparam int IDX_W      = 3;
	localparam int EV_W       = 5;
	localparam int THR_W      = 20;
	localparam int COUNT_W    = 4;
	localparam int MASKS_W    = 40;
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 40;

	localparam logic [EV_W-1:0] EV_PRESS   = 5'b00001;
	localparam logic [EV_W-1:0] EV_RELEASE = 5'b00010;
	localparam logic [EV_W-1:0] EV_SHORT   = 5'b00100;
	localparam logic [EV_W-1:0] EV_LONG    = 5'b01000;
	localparam logic [EV_W-1:0] EV_VLONG   = 5'b10000;

	localparam logic [THR_W-1:0] SHORT_RST = 20'd50;
	localparam logic [THR_W-1:0] LONG_RST  = 20'd3000;
	localparam logic [THR_W-1:0] VLONG_RST = 20'd10000;

	localparam logic [CFG_ADDR_W-1:0] REG_BUTTON_COUNT = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_TRIGGER_MASKS = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_SHORT_TICKS = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_LONG_TICKS = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] REG_VLONG_TICKS = 3'd4;

	localparam logic OP_TICK = 1'b0;
	localparam logic OP_EDGE = 1'b1;

	typedef struct packed {
		logic [THR_W-1:0] short_t;
		logic [THR_W-1:0] long_t;
		logic [THR_W-1:0] vlong_t;
	} thr_t;

	// broadcast from the sequencer to every cell
	typedef struct packed {
		logic             tick;
		logic             edge_en;
		logic [IDX_W-1:0] edge_idx;
		logic             level;
		logic             step;
	} cell_ctrl_t;

	// per-cell contribution, ORed across the row
	typedef struct packed {
		logic [EV_W-1:0]  edge_ev;
		logic [EV_W-1:0]  sel_ev;
		logic [IDX_W-1:0] sel_slot;
		logic             sel_tail;
	} cell_tap_t;

endpackage

// File: rtl/button_press_duration_classifier.sv
// ----------------------------------------------------------------------------
// button_press_duration_classifier: short/long press detector for a row of buttons
// An edge item passes ST_EDGE before its scan, a tick item starts the scan at once;
// the scan token walks the cell row one slot per cycle while the output does not stall.
// One item in flight; the next is taken once the scan of the last one ends.
// Reset (arst_n low, asynchronous) releases all buttons, zeroes counters and
// reported masks, and loads the register reset values.
// ----------------------------------------------------------------------------
module button_press_duration_classifier #(
	parameter int BUTTONS    = bpdc_pkg::BUTTONS_DEF,
	parameter int TICK_WIDTH = bpdc_pkg::TICK_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [7:0]                      s_axis_tdata,  // button_index[2:0], level, pad
	input  logic                            s_axis_tuser,  // opcode
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [7:0]                      m_axis_tdata,  // button_slot[2:0], trigger_bits[4:0]
	output logic                            m_axis_tlast,
	input  logic                            cfg_we,
	input  logic [bpdc_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [bpdc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import bpdc_pkg::*;

	typedef enum logic [1:0] {ST_IDLE, ST_EDGE, ST_SCAN} state_t;

	state_t state_q;

	logic [COUNT_W-1:0] count_q;
	logic [MASKS_W-1:0] masks_q;
	thr_t               thr_q;

	logic [EV_W-1:0]  edge_ev_q;
	logic [IDX_W-1:0] edge_slot_q;
	logic [IDX_W-1:0] out_slot_q;
	logic [EV_W-1:0]  out_ev_q;
	logic             out_last_q;
	logic             out_valid_q;

	logic             in_opcode;
	logic [IDX_W-1:0] in_idx;
	logic             in_level;
	logic             accept;
	logic             out_free;
	logic             out_load;
	logic             start;
	logic             scan_step;
	logic             has_ev;

	cell_ctrl_t ctrl;
	cell_tap_t  taps [BUTTONS];
	cell_tap_t  tap_or;
	logic [BUTTONS:0] tok_link;
	logic [BUTTONS:0] any_link;

	assign in_opcode = s_axis_tuser;
	assign in_idx    = s_axis_tdata[2:0];
	assign in_level  = s_axis_tdata[3];

	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;

	always_comb begin
		tap_or = '0;
		for (int i = 0; i < BUTTONS; i++) begin
			tap_or = tap_or | taps[i];
		end
	end

	assign has_ev    = (tap_or.sel_ev != '0);
	assign scan_step = (state_q == ST_SCAN) && (!has_ev || out_free);
	assign start     = (accept && in_opcode == OP_TICK) ||
	                   ((state_q == ST_EDGE) && ((edge_ev_q == '0) || out_free));
	assign out_load  = ((state_q == ST_EDGE) && (edge_ev_q != '0) && out_free) ||
	                   ((state_q == ST_SCAN) && has_ev && out_free);

	assign ctrl.tick     = accept && (in_opcode == OP_TICK);
	assign ctrl.edge_en  = accept && (in_opcode == OP_EDGE);
	assign ctrl.edge_idx = in_idx;
	assign ctrl.level    = in_level;
	assign ctrl.step     = scan_step || start;

	assign tok_link[0]       = start;
	assign any_link[BUTTONS] = 1'b0;

	for (genvar g = 0; g < BUTTONS; g++) begin : g_cell
		bpdc_cell #(
			.SLOT       (g),
			.TICK_WIDTH (TICK_WIDTH)
		) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.ctrl         (ctrl),
			.button_count (count_q),
			.mask         (masks_q[g*EV_W +: EV_W]),
			.thr          (thr_q),
			.tok_in       (tok_link[g]),
			.tok_out      (tok_link[g+1]),
			.any_in       (any_link[g+1]),
			.any_out      (any_link[g]),
			.tap          (taps[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q       <= '0;
			masks_q       <= '0;
			thr_q.short_t <= SHORT_RST;
			thr_q.long_t  <= LONG_RST;
			thr_q.vlong_t <= VLONG_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_BUTTON_COUNT:  count_q       <= cfg_wdata[COUNT_W-1:0];
				REG_TRIGGER_MASKS: masks_q       <= cfg_wdata[MASKS_W-1:0];
				REG_SHORT_TICKS:   thr_q.short_t <= cfg_wdata[THR_W-1:0];
				REG_LONG_TICKS:    thr_q.long_t  <= cfg_wdata[THR_W-1:0];
				REG_VLONG_TICKS:   thr_q.vlong_t <= cfg_wdata[THR_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			edge_ev_q   <= '0;
			edge_slot_q <= '0;
			out_slot_q  <= '0;
			out_ev_q    <= '0;
			out_last_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (m_axis_tready && !out_load) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						edge_ev_q   <= tap_or.edge_ev;
						edge_slot_q <= in_idx;
						state_q     <= (in_opcode == OP_EDGE) ? ST_EDGE : ST_SCAN;
					end
				end
				ST_EDGE: begin
					// edge result is last unless some pressed slot still has an event
					if (edge_ev_q == '0) begin
						state_q <= ST_SCAN;
					end else if (out_free) begin
						out_valid_q <= 1'b1;
						out_slot_q  <= edge_slot_q;
						out_ev_q    <= edge_ev_q;
						out_last_q  <= !any_link[0];
						state_q     <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (has_ev && out_free) begin
						out_valid_q <= 1'b1;
						out_slot_q  <= tap_or.sel_slot;
						out_ev_q    <= tap_or.sel_ev;
						out_last_q  <= !tap_or.sel_tail;
					end
					if (scan_step && tok_link[BUTTONS]) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_ev_q, out_slot_q};
	assign m_axis_tlast  = out_last_q;

endmodule

// File: rtl/bpdc_cell.sv
// ----------------------------------------------------------------------------
// bpdc_cell: state of one button slot
// Holds pressed flag, held-tick counter and reported mask, classifies the
// held time, and passes the scan token and the pending-event flag along.
// ----------------------------------------------------------------------------
module bpdc_cell #(
	parameter int SLOT       = 0,
	parameter int TICK_WIDTH = bpdc_pkg::TICK_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  bpdc_pkg::cell_ctrl_t        ctrl,
	input  logic [bpdc_pkg::COUNT_W-1:0] button_count,
	input  logic [bpdc_pkg::EV_W-1:0]   mask,
	input  bpdc_pkg::thr_t              thr,
	input  logic                        tok_in,
	output logic                        tok_out,
	input  logic                        any_in,
	output logic                        any_out,
	output bpdc_pkg::cell_tap_t         tap
);
	import bpdc_pkg::*;

	localparam int CMP_W = (TICK_WIDTH > THR_W) ? TICK_WIDTH : THR_W;
	localparam logic [TICK_WIDTH-1:0] TICK_MAX = {TICK_WIDTH{1'b1}};

	logic                  pressed_q;
	logic [TICK_WIDTH-1:0] held_q;
	logic [EV_W-1:0]       reported_q;
	logic                  tok_q;

	logic            active;
	logic            hit;
	logic [CMP_W-1:0] held_x;
	logic [EV_W-1:0] cls;
	logic [EV_W-1:0] edge_ev;
	logic [EV_W-1:0] scan_ev;

	assign active = COUNT_W'(SLOT) < button_count;
	assign hit    = ctrl.edge_en && (ctrl.edge_idx == IDX_W'(SLOT)) && active;
	assign held_x = CMP_W'(held_q);

	always_comb begin
		if (held_x > CMP_W'(thr.vlong_t)) begin
			cls = EV_VLONG;
		end else if (held_x > CMP_W'(thr.long_t)) begin
			cls = EV_LONG;
		end else if (held_x > CMP_W'(thr.short_t)) begin
			cls = EV_SHORT;
		end else begin
			cls = '0;
		end
	end

	// a press clears the reported mask before filtering
	always_comb begin
		if (ctrl.level) begin
			edge_ev = EV_PRESS & mask;
		end else begin
			edge_ev = (EV_RELEASE | cls) & mask & ~reported_q;
		end
	end

	assign scan_ev = (pressed_q && active) ? (cls & mask & ~reported_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pressed_q  <= 1'b0;
			held_q     <= '0;
			reported_q <= '0;
			tok_q      <= 1'b0;
		end else begin
			if (ctrl.tick && held_q != TICK_MAX) begin
				held_q <= held_q + 1'b1;
			end
			if (hit) begin
				held_q     <= '0;
				pressed_q  <= ctrl.level;
				reported_q <= ctrl.level ? edge_ev : (reported_q | edge_ev);
			end
			if (ctrl.step) begin
				tok_q <= tok_in;
				if (tok_q) begin
					reported_q <= reported_q | scan_ev;
				end
			end
		end
	end

	assign tok_out = tok_q;
	assign any_out = (scan_ev != '0) || any_in;

	assign tap.edge_ev  = hit ? edge_ev : '0;
	assign tap.sel_ev   = tok_q ? scan_ev : '0;
	assign tap.sel_slot = tok_q ? IDX_W'(SLOT) : '0;
	assign tap.sel_tail = tok_q && any_in;

endmodule

// File: verif/tb_button_press_duration_classifier.sv
// ----------------------------------------------------------------------------
// tb_button_press_duration_classifier: self-checking bench for the classifier
// Sends tick and level-change items and predicts each slot's press, release
// and duration-class events. Every output item is checked in order against
// the prediction, under several register settings and handshake idling mixes.
// ----------------------------------------------------------------------------
module tb_button_press_duration_classifier;
	import bpdc_pkg::*;

	localparam int NSLOTS     = BUTTONS_DEF;
	localparam int DRAIN      = 3 * (NSLOTS + 2);
	localparam int QUIET_MAX  = 20000;
	localparam int HOLD_LEN   = 400;
	localparam logic [THR_W-1:0] THR_TOP = '1;

	typedef struct packed {
		logic [IDX_W-1:0] slot;
		logic [EV_W-1:0]  bits;
		logic             last;
	} press_event_t;

	class press_scoreboard;
		logic [COUNT_W-1:0] button_count;
		logic [MASKS_W-1:0] trig_masks;
		logic [THR_W-1:0]   thr_short, thr_long, thr_vlong;
		bit                 pressed[NSLOTS];
		logic [THR_W-1:0]   held[NSLOTS];
		logic [EV_W-1:0]    reported[NSLOTS];
		press_event_t       pending_events[$];
		int                 errors, n_items, n_checked;

		function new();
			button_count = '0;
			trig_masks = '0;
			thr_short = SHORT_RST;
			thr_long = LONG_RST;
			thr_vlong = VLONG_RST;
			foreach (pressed[s]) begin
				pressed[s] = 0;
				held[s] = '0;
				reported[s] = '0;
			end
		endfunction

		task report(string what);
			errors++;
			if (errors <= 30)
				$display("[%0t] mismatch: %s", $time, what);
		endtask

		function void set_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
			case (addr)
				REG_BUTTON_COUNT:  button_count = data[COUNT_W-1:0];
				REG_TRIGGER_MASKS: trig_masks = data[MASKS_W-1:0];
				REG_SHORT_TICKS:   thr_short = data[THR_W-1:0];
				REG_LONG_TICKS:    thr_long = data[THR_W-1:0];
				REG_VLONG_TICKS:   thr_vlong = data[THR_W-1:0];
				default: ;
			endcase
		endfunction

		function int active_slots();
			return (button_count > NSLOTS) ? NSLOTS : int'(button_count);
		endfunction

		// longest class exceeded, strict compare
		function logic [EV_W-1:0] duration_class(logic [THR_W-1:0] t);
			if (t > thr_vlong) return EV_VLONG;
			if (t > thr_long) return EV_LONG;
			if (t > thr_short) return EV_SHORT;
			return '0;
		endfunction

		function logic [EV_W-1:0] new_events(int s, logic [EV_W-1:0] ev);
			ev &= trig_masks[5*s +: EV_W];
			ev &= ~reported[s];
			reported[s] |= ev;
			return ev;
		endfunction

		// predict the output items of one accepted input item;
		// returns 1 when the item is not simply ignored
		function bit note_item(logic op, logic [IDX_W-1:0] idx, logic lvl);
			int active;
			bit used;
			logic [EV_W-1:0] ev;
			press_event_t found[$];
			press_event_t one;
			active = active_slots();
			used = 0;
			n_items++;
			if (op == OP_TICK) begin
				used = 1;
				foreach (held[s])
					if (held[s] != '1)
						held[s]++;
			end else if (int'(idx) < active) begin
				used = 1;
				if (lvl) begin
					reported[idx] = '0;
					ev = EV_PRESS;
					pressed[idx] = 1;
				end else begin
					ev = EV_RELEASE | duration_class(held[idx]);
					pressed[idx] = 0;
				end
				held[idx] = '0;
				ev = new_events(idx, ev);
				if (ev != '0) begin
					one.slot = idx;
					one.bits = ev;
					one.last = 0;
					found.push_back(one);
				end
			end
			for (int s = 0; s < active; s++) begin
				if (pressed[s]) begin
					ev = new_events(s, duration_class(held[s]));
					if (ev != '0) begin
						one.slot = IDX_W'(s);
						one.bits = ev;
						one.last = 0;
						found.push_back(one);
					end
				end
			end
			if (found.size() > 0)
				found[found.size()-1].last = 1;
			foreach (found[i])
				pending_events.push_back(found[i]);
			return used;
		endfunction

		task check_result(logic [IDX_W-1:0] slot, logic [EV_W-1:0] bits, logic last);
			press_event_t want;
			n_checked++;
			if (pending_events.size() == 0) begin
				report($sformatf("unexpected item slot=%0d bits=%b last=%b", slot, bits, last));
			end else begin
				want = pending_events.pop_front();
				if (slot !== want.slot)
					report($sformatf("slot %0d, expected %0d", slot, want.slot));
				if (bits !== want.bits)
					report($sformatf("slot %0d bits %b, expected %b", want.slot, bits, want.bits));
				if (last !== want.last)
					report($sformatf("slot %0d last %b, expected %b", want.slot, last, want.last));
			end
		endtask
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [7:0]            s_axis_tdata;
	logic                  s_axis_tuser;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [7:0]            m_axis_tdata;
	logic                  m_axis_tlast;
	logic                  cfg_we;
	logic [CFG_ADDR_W-1:0] cfg_addr;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	press_scoreboard sb;
	int idle_pct;
	int stall_pct;
	int hold_cycles;
	int quiet;
	int n_settings;

	button_press_duration_classifier dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata)
	);

	always #5 clk = ~clk;

	// output side: check, then decide ready for the next cycle
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready)
				sb.check_result(m_axis_tdata[2:0], m_axis_tdata[7:3], m_axis_tlast);
			if (hold_cycles > 0) begin
				hold_cycles--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
				quiet <= 0;
			else
				quiet <= quiet + 1;
			if (quiet >= QUIET_MAX) begin
				$display("watchdog: no handshake for %0d cycles", quiet);
				$display("FAIL button_press_duration_classifier");
				$finish;
			end
		end
	end

	// one item, optional gap first; returns with the item accepted
	task send_item(input logic op, input logic [IDX_W-1:0] idx, input logic lvl,
			output bit used);
		int gap;
		gap = 0;
		while (idle_pct > 0 && $urandom_range(99) < idle_pct)
			gap++;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= {4'b0000, lvl, idx};
		do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
		used = sb.note_item(op, idx, lvl);
	endtask

	// all five registers plus one write to an unused index, which must be ignored
	task configure(input logic [COUNT_W-1:0] cnt, input logic [MASKS_W-1:0] masks,
			input logic [THR_W-1:0] t_short, input logic [THR_W-1:0] t_long,
			input logic [THR_W-1:0] t_vlong);
		logic [CFG_ADDR_W-1:0] addr[6];
		logic [CFG_DATA_W-1:0] data[6];
		addr[0] = CFG_ADDR_W'(REG_VLONG_TICKS + 1 + $urandom_range(2));
		data[0] = {8'($urandom), 32'($urandom)};
		addr[1] = REG_BUTTON_COUNT;  data[1] = CFG_DATA_W'(cnt);
		addr[2] = REG_TRIGGER_MASKS; data[2] = CFG_DATA_W'(masks);
		addr[3] = REG_SHORT_TICKS;   data[3] = CFG_DATA_W'(t_short);
		addr[4] = REG_LONG_TICKS;    data[4] = CFG_DATA_W'(t_long);
		addr[5] = REG_VLONG_TICKS;   data[5] = CFG_DATA_W'(t_vlong);
		for (int i = 0; i < 6; i++) begin
			cfg_we <= 1'b1;
			cfg_addr <= addr[i];
			cfg_wdata <= data[i];
			@(posedge clk);
			sb.set_reg(addr[i], data[i]);
		end
		cfg_we <= 1'b0;
		n_settings++;
	endtask

	task drain();
		s_axis_tvalid <= 1'b0;
		while (sb.pending_events.size() > 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	// mostly ticks and well-formed press/release pairs, some random level noise
	task random_run(input int n);
		int done;
		int r;
		logic [IDX_W-1:0] idx;
		logic lvl;
		bit used;
		done = 0;
		while (done < n) begin
			r = $urandom_range(99);
			idx = IDX_W'($urandom_range(NSLOTS - 1));
			lvl = ~sb.pressed[idx];
			if (r >= 85)
				lvl = 1'($urandom_range(1));
			if (r < 55)
				send_item(OP_TICK, idx, lvl, used);
			else if (r < 85)
				send_item(OP_EDGE, idx, ~sb.pressed[idx], used);
			else
				send_item(OP_EDGE, idx, lvl, used);
			if (used)
				done++;
		end
	endtask

	initial begin
		bit used;
		sb = new();
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		cfg_we = 1'b0;
		cfg_addr = '0;
		cfg_wdata = '0;
		idle_pct = 0;
		stall_pct = 0;
		hold_cycles = 0;
		quiet = 0;
		n_settings = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// no slots registered: every level change is dropped, ticks still count
		send_item(OP_EDGE, 3'd0, 1'b1, used);
		send_item(OP_TICK, 3'd7, 1'b1, used);
		send_item(OP_EDGE, 3'd7, 1'b0, used);
		drain();
		configure(4'd0, '0, SHORT_RST, LONG_RST, VLONG_RST);
		send_item(OP_EDGE, 3'd5, 1'b1, used);
		send_item(OP_TICK, 3'd0, 1'b0, used);
		drain();

		// directed: class progression, release without press, repeated press
		configure(4'd8, '1, 20'd1, 20'd3, 20'd6);
		send_item(OP_EDGE, 3'd0, 1'b1, used);
		repeat (7) send_item(OP_TICK, 3'd0, 1'b0, used);
		send_item(OP_EDGE, 3'd0, 1'b0, used);
		send_item(OP_EDGE, 3'd5, 1'b0, used);
		send_item(OP_EDGE, 3'd7, 1'b1, used);
		send_item(OP_EDGE, 3'd7, 1'b1, used);
		send_item(OP_EDGE, 3'd7, 1'b0, used);
		send_item(OP_EDGE, 3'd3, 1'b1, used);
		send_item(OP_EDGE, 3'd2, 1'b1, used);
		repeat (4) send_item(OP_TICK, 3'd0, 1'b0, used);
		send_item(OP_EDGE, 3'd3, 1'b0, used);
		drain();

		idle_pct = 88;
		configure(4'd5, {8'($urandom), 32'($urandom)}, 20'd2, 20'd6, 20'd11);
		random_run(90);
		drain();

		// oversized count, zero thresholds; long output hold-off fills the block
		idle_pct = 0;
		stall_pct = 88;
		configure(4'd15, '1, '0, '0, '0);
		hold_cycles = HOLD_LEN;
		random_run(90);
		drain();

		// thresholds out of order
		idle_pct = 34;
		stall_pct = 34;
		configure(4'd3, {8'($urandom), 32'($urandom)}, 20'd10, 20'd4, 20'd7);
		random_run(90);
		drain();

		idle_pct = 0;
		stall_pct = 0;
		configure(4'd8, {8'($urandom), 32'($urandom)}, THR_TOP, THR_TOP, THR_TOP);
		random_run(60);
		drain();

		idle_pct = 34;
		configure(4'd7, '1, 20'd4, 20'd9, 20'd16);
		random_run(60);
		drain();

		$display("run covered %0d input items and %0d output items", sb.n_items, sb.n_checked);
		$display("over %0d register settings, idle and stall mixes, one long hold-off",
			n_settings);
		if (sb.errors == 0 && sb.pending_events.size() == 0) begin
			$display("PASS button_press_duration_classifier");
		end else begin
			$display("%0d mismatches, %0d items never seen", sb.errors,
				sb.pending_events.size());
			$display("FAIL button_press_duration_classifier");
		end
		$finish;
	end

endmodule

// File: sim.f
rtl/bpdc_pkg.sv
rtl/bpdc_cell.sv
rtl/button_press_duration_classifier.sv
verif/tb_button_press_duration_classifier.sv
